/* rtl/core/tcobr_pkg.sv */
// ---------------------------------------------------------------------------
// tcobr_pkg
// Shared types and constants for the two-channel optical byte receiver.
// ---------------------------------------------------------------------------
package tcobr_pkg;

   localparam int HISTORY_DEPTH = 10;
   localparam int LEVEL_W       = 8;
   localparam int HOLD_W        = 4;
   localparam int WINDOW_W      = 4;
   localparam int COUNT_W       = 4;
   localparam int SHIFT_W       = 9;
   localparam int BYTE_W        = 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   localparam logic [COUNT_W-1:0] BITS_PER_FRAME = COUNT_W'(SHIFT_W);

   localparam logic [HOLD_W-1:0]   HOLD_RESET      = HOLD_W'(3);
   localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = LEVEL_W'(10);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET    = WINDOW_W'(10);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_FRAMES     = 2'd0,
      CSR_LEVEL_THRESHOLD = 2'd1,
      CSR_START_WINDOW    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] sync_level;
      logic [LEVEL_W-1:0] data_level;
      logic               frame_found;
      logic               abort;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              byte_ready;
      logic              parity_error;
      logic              sync_on;
      logic              data_on;
      logic              receiving;
   } rsp_data_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_threshold;
      logic [HOLD_W-1:0]  hold_frames;
   } chan_cfg_type;

endpackage

/* rtl/core/two_channel_optical_byte_receiver.sv */
// A beat accepted from req_ is held in the input register; its result then goes to
// the result register on rsp_. Throughput: one beat per cycle while rsp_stall is low;
// the two registers decouple the channels: rsp_stall holds off req_ only when both are full.
// Reset (synchronous, active high) clears histories, start timer, transfer flag,
// bit count and valids, and restores the register defaults 3, 10 and 10.
// ---------------------------------------------------------------------------
// two_channel_optical_byte_receiver
// Qualifies sync/data spots and assembles parity-checked bytes.
// ---------------------------------------------------------------------------
module two_channel_optical_byte_receiver
   import tcobr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   chan_cfg_type        cfg_ff;
   logic [WINDOW_W-1:0] window_ff;

   logic                in_valid_ff;
   logic                in_valid_in;
   req_data_type        in_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_data_type        rsp_data_ff;
   rsp_data_type        rsp_data_in;

   logic [WINDOW_W-1:0] timer_ff;
   logic [WINDOW_W-1:0] timer_in;
   logic                xfer_ff;
   logic                xfer_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [SHIFT_W-1:0]  shift_ff;
   logic [SHIFT_W-1:0]  shift_in;

   logic                out_free;
   logic                advance;
   logic                load_in;
   logic                sync_on;
   logic                data_on;
   logic                do_shift;
   logic                shift_bit;
   logic [BYTE_W-1:0]   byte_val;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load_in   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_frames     <= HOLD_RESET;
         cfg_ff.level_threshold <= THRESHOLD_RESET;
         window_ff              <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLD_FRAMES:     cfg_ff.hold_frames     <= csr_wdata[HOLD_W-1:0];
            CSR_LEVEL_THRESHOLD: cfg_ff.level_threshold <= csr_wdata[LEVEL_W-1:0];
            CSR_START_WINDOW:    window_ff              <= csr_wdata[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tcobr_chan u_sync (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .level       (in_data_ff.sync_level),
      .frame_found (in_data_ff.frame_found),
      .cfg         (cfg_ff),
      .chan_on     (sync_on)
   );

   tcobr_chan u_data (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .level       (in_data_ff.data_level),
      .frame_found (in_data_ff.frame_found),
      .cfg         (cfg_ff),
      .chan_on     (data_on)
   );

   always_comb begin
      timer_in  = (timer_ff != '0) ? timer_ff - WINDOW_W'(1) : timer_ff;
      xfer_in   = xfer_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      do_shift  = 1'b0;
      shift_bit = 1'b0;

      if (sync_on && !data_on) begin
         timer_in = window_ff;
         do_shift = xfer_ff;
      end else if (!sync_on && data_on) begin
         if ((timer_in != '0) && !xfer_ff) begin
            xfer_in  = 1'b1;
            count_in = '0;
         end
      end else if (sync_on && data_on) begin
         do_shift  = xfer_ff;
         shift_bit = 1'b1;
      end

      if (do_shift) begin
         shift_in = {shift_ff[SHIFT_W-2:0], shift_bit};
         count_in = count_ff + COUNT_W'(1);
      end

      byte_val                 = shift_in[SHIFT_W-1:1];
      rsp_data_in.byte_value   = '0;
      rsp_data_in.byte_ready   = 1'b0;
      rsp_data_in.parity_error = 1'b0;
      if (count_in == BITS_PER_FRAME) begin
         if ((^byte_val) == shift_in[0]) begin
            rsp_data_in.byte_ready = 1'b1;
            rsp_data_in.byte_value = byte_val;
         end else begin
            rsp_data_in.parity_error = 1'b1;
         end
         xfer_in  = 1'b0;
         count_in = '0;
      end

      if (in_data_ff.abort) begin
         count_in = '0;
      end

      rsp_data_in.sync_on   = sync_on;
      rsp_data_in.data_on   = data_on;
      rsp_data_in.receiving = xfer_in;

      in_valid_in  = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timer_ff     <= '0;
         xfer_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            timer_ff <= timer_in;
            xfer_ff  <= xfer_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         shift_ff    <= shift_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < BITS_PER_FRAME)
      else $error("bit count reached a full frame without completing");

   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.byte_ready && rsp_data_ff.parity_error))
      else $error("byte ready and parity error together");

   a_done_ends_xfer: assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_data_in.byte_ready || rsp_data_in.parity_error) |=> !xfer_ff)
      else $error("transfer still running after a completed frame");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.byte_ready |-> rsp_data_ff.byte_value == '0)
      else $error("byte value set without a ready byte");

   a_receiving: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_data_ff.receiving == xfer_ff)
      else $error("receiving flag differs from transfer state");

endmodule

/* rtl/core/tcobr_chan.sv */
// ---------------------------------------------------------------------------
// tcobr_chan
// Per-channel bright/dark history and hold qualification.
// ---------------------------------------------------------------------------
module tcobr_chan
   import tcobr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [LEVEL_W-1:0] level,
   input  logic               frame_found,
   input  chan_cfg_type       cfg,
   output logic               chan_on
);

   logic [HISTORY_DEPTH-1:0] hist_ff;
   logic [HISTORY_DEPTH-1:0] hist_in;
   logic [HISTORY_DEPTH-1:0] pushed;
   logic [HISTORY_DEPTH-1:0] mask;
   logic                     flag;

   always_comb begin
      flag   = frame_found ? (level > cfg.level_threshold) : hist_ff[0];
      pushed = (hist_ff << 1) | HISTORY_DEPTH'(flag);
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         mask[i] = (i < int'(cfg.hold_frames));
      end
      chan_on = ((pushed & mask) == mask);
      hist_in = chan_on ? (pushed & ~mask) : pushed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (advance) begin
         hist_ff <= hist_in;
      end
   end

endmodule
